>>> sv/rtcb_pkg.sv
package rtcb_pkg;

    // Number of time fields carried in one burst
    localparam int NUM_FIELDS = 7;

    // Command and data bytes sent on the serial link
    localparam logic [7:0] CMD_BURST = 8'hBE;
    localparam logic [7:0] CMD_WP    = 8'h8E;
    localparam logic [7:0] READ_BIT  = 8'h81;
    localparam logic [7:0] WRITE_BIT = 8'h80;
    localparam logic [7:0] WP_ON     = 8'h80;
    localparam logic [7:0] WP_OFF    = 8'h00;

    // Per-field limits for set values and masks for read bytes
    localparam logic [7:0] SET_LIMIT [NUM_FIELDS] =
        '{8'd60, 8'd60, 8'd24, 8'd32, 8'd13, 8'd8, 8'd100};
    localparam logic [7:0] READ_MASK [NUM_FIELDS] =
        '{8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'h07, 8'h7F};

    // Largest quotient that any limit can give on an 8-bit value
    localparam int MOD_MAX_QUOT = 255 / 8;

    // Sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_RD_CMD  = 4'd1,
        ST_RD_DATA = 4'd2,
        ST_RD_END  = 4'd3,
        ST_WP_CMD  = 4'd4,
        ST_WP_DATA = 4'd5,
        ST_WP_END  = 4'd6,
        ST_BU_CMD  = 4'd7,
        ST_BU_DATA = 4'd8,
        ST_SET_END = 4'd9
    } rtcb_step_t;

    // One request: a half-bit tick with an optional start
    typedef struct packed {
        logic       start_req;
        logic       req_type;
        logic [7:0] set_second;
        logic [7:0] set_minute;
        logic [7:0] set_hour;
        logic [7:0] set_day;
        logic [7:0] set_month;
        logic [7:0] set_weekday;
        logic [7:0] set_year;
        logic       sda_in;
    } rtcb_in_t;

    // One result: pin levels, done pulse and the last time read
    typedef struct packed {
        logic       sclk;
        logic       sda_out;
        logic       sda_drive;
        logic       chip_enable;
        logic       done_res;
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] day;
        logic [4:0] month;
        logic [2:0] weekday;
        logic [6:0] year;
    } rtcb_out_t;

    // Remainder by a small constant through parallel compares against its multiples
    function automatic logic [7:0] mod_small(input logic [7:0] x, input logic [7:0] lim);
        logic [7:0]  r;
        logic [15:0] m;
        r = x;
        for (int k = 1; k <= MOD_MAX_QUOT; k++) begin
            m = 16'(k) * {8'd0, lim};
            if ({8'd0, x} >= m) begin
                r = x - m[7:0];
            end
        end
        return r;
    endfunction

    // Binary below one hundred to two BCD digits
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [3:0] tens;
        logic [3:0] ones;
        logic [7:0] m;
        tens = 4'd0;
        ones = v[3:0];
        for (int k = 1; k <= 9; k++) begin
            m = 8'(k * 10);
            if (v >= m) begin
                tens = 4'(k);
                ones = 4'(v - m);
            end
        end
        return {tens, ones};
    endfunction

    // Masked BCD byte (at most 0x7F) to binary
    function automatic logic [6:0] from_bcd(input logic [7:0] b);
        logic [2:0] hi;
        hi = b[6:4];
        return 7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(b[3:0]);
    endfunction

endpackage

>>> sv/rtc_three_wire_burst_master_core.sv
// A request waits in the request register, its result in the result register.
// One request per cycle unless results stall; sequencer updates once per request.
// The result register lets the next request enter while a result waits to be taken.
// Reset (rst_n low, asynchronous) empties both registers, sets the sequencer idle,
// and clears the shift byte, bit and byte counters and the stored time to zero.
module rtc_three_wire_burst_master_core
    import rtcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rtcb_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output rtcb_out_t out_data
);

    logic                        in_vld_reg,  in_vld_next;
    rtcb_in_t                    in_reg;
    logic                        out_vld_reg, out_vld_next;
    rtcb_out_t                   out_reg;
    logic                        advance;
    logic [NUM_FIELDS-1:0][7:0]  set_bcd;
    rtcb_out_t                   result;

    // The held request moves on when the result register is free or being emptied
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Valid flags of the two registers
    always_comb
    begin
        if (in_valid && in_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end

        if (advance) begin
            out_vld_next = 1'b1;
        end else if (out_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Request and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_reg <= in_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    // Set value conversion
    rtcb_conv u_conv (
        .item    (in_reg),
        .set_bcd (set_bcd)
    );

    // Sequencer and pin logic
    rtcb_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .item    (in_reg),
        .set_bcd (set_bcd),
        .result  (result)
    );

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

>>> sv/rtcb_conv.sv
module rtcb_conv
    import rtcb_pkg::*;
(
    input  rtcb_in_t                      item,
    output logic [NUM_FIELDS-1:0][7:0]    set_bcd
);

    logic [7:0] raw [NUM_FIELDS];

    // Gather the set values in burst order
    always_comb
    begin
        raw[0] = item.set_second;
        raw[1] = item.set_minute;
        raw[2] = item.set_hour;
        raw[3] = item.set_day;
        raw[4] = item.set_month;
        raw[5] = item.set_weekday;
        raw[6] = item.set_year;
    end

    // Reduce each value by its limit and encode it as BCD
    always_comb
    begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            set_bcd[i] = to_bcd(mod_small(raw[i], SET_LIMIT[i]));
        end
    end

endmodule

>>> sv/rtcb_engine.sv
module rtcb_engine
    import rtcb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  rtcb_in_t                      item,
    input  logic [NUM_FIELDS-1:0][7:0]    set_bcd,
    output rtcb_out_t                     result
);

    rtcb_step_t  step_reg,     step_next;
    logic        phase_reg,    phase_next;
    logic [2:0]  bit_idx_reg,  bit_idx_next;
    logic [3:0]  byte_idx_reg, byte_idx_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [6:0]  time_reg  [NUM_FIELDS];
    logic [6:0]  time_next [NUM_FIELDS];
    logic [7:0]  pend_reg  [NUM_FIELDS];
    logic [7:0]  pend_next [NUM_FIELDS];

    logic        sclk;
    logic        sda;
    logic        drive;
    logic        ce;
    logic        done;
    logic        reading;
    logic        byte_done;
    logic [2:0]  slot;

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg     <= ST_IDLE;
            phase_reg    <= 1'b0;
            bit_idx_reg  <= 3'd0;
            byte_idx_reg <= 4'd0;
            shift_reg    <= 8'd0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                time_reg[i] <= 7'd0;
            end
        end else if (en) begin
            step_reg     <= step_next;
            phase_reg    <= phase_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            shift_reg    <= shift_next;
            time_reg     <= time_next;
        end
    end

    // Pending set bytes are only read after a set request has loaded them
    always_ff @(posedge clk)
    begin
        if (en) begin
            pend_reg <= pend_next;
        end
    end

    // Next step, pin levels and captured time for one tick
    always_comb
    begin
        step_next     = step_reg;
        phase_next    = phase_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        shift_next    = shift_reg;
        time_next     = time_reg;
        pend_next     = pend_reg;
        sclk          = 1'b0;
        sda           = 1'b1;
        drive         = 1'b1;
        ce            = 1'b0;
        done          = 1'b0;
        reading       = 1'b0;
        byte_done     = 1'b0;
        slot          = 3'd0;

        // A start is taken only while idle
        if (step_reg == ST_IDLE && item.start_req) begin
            phase_next    = 1'b0;
            bit_idx_next  = 3'd0;
            byte_idx_next = 4'd0;
            if (item.req_type) begin
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    pend_next[i] = set_bcd[i];
                end
                step_next  = ST_WP_CMD;
                shift_next = WRITE_BIT | CMD_WP;
            end else begin
                step_next  = ST_RD_CMD;
                shift_next = READ_BIT | CMD_BURST;
            end
        end

        unique case (step_next)
            ST_IDLE:
            begin
            end
            ST_RD_END, ST_SET_END:
            begin
                done      = 1'b1;
                step_next = ST_IDLE;
            end
            ST_WP_END:
            begin
                step_next    = ST_BU_CMD;
                shift_next   = WRITE_BIT | CMD_BURST;
                phase_next   = 1'b0;
                bit_idx_next = 3'd0;
            end
            ST_RD_CMD, ST_RD_DATA, ST_WP_CMD, ST_WP_DATA, ST_BU_CMD, ST_BU_DATA:
            begin
                reading = (step_next == ST_RD_DATA);
                ce      = 1'b1;
                drive   = !reading;
                if (!phase_next) begin
                    // Low half of the bit: sample when reading, present when writing
                    sclk = 1'b0;
                    if (reading) begin
                        shift_next = {item.sda_in, shift_next[7:1]};
                        sda        = 1'b0;
                    end else begin
                        sda = shift_next[0];
                    end
                    phase_next = 1'b1;
                end else begin
                    // High half of the bit: shift on when writing
                    sclk = 1'b1;
                    if (reading) begin
                        sda = 1'b0;
                    end else begin
                        sda        = shift_next[0];
                        shift_next = {1'b0, shift_next[7:1]};
                    end
                    phase_next = 1'b0;
                    if (bit_idx_next == 3'd7) begin
                        bit_idx_next = 3'd0;
                        byte_done    = 1'b1;
                    end else begin
                        bit_idx_next = bit_idx_next + 3'd1;
                    end
                end

                // Byte boundary: move on within the transaction
                if (byte_done) begin
                    unique case (step_next)
                        ST_RD_CMD:
                        begin
                            step_next     = ST_RD_DATA;
                            byte_idx_next = 4'd0;
                            shift_next    = 8'd0;
                        end
                        ST_RD_DATA:
                        begin
                            slot            = byte_idx_next[2:0];
                            time_next[slot] = from_bcd(shift_next & READ_MASK[slot]);
                            byte_idx_next   = byte_idx_next + 4'd1;
                            shift_next      = 8'd0;
                            if (byte_idx_next >= 4'(NUM_FIELDS)) begin
                                step_next = ST_RD_END;
                            end
                        end
                        ST_WP_CMD:
                        begin
                            step_next  = ST_WP_DATA;
                            shift_next = WP_OFF;
                        end
                        ST_WP_DATA:
                        begin
                            step_next = ST_WP_END;
                        end
                        ST_BU_CMD:
                        begin
                            step_next     = ST_BU_DATA;
                            byte_idx_next = 4'd0;
                            shift_next    = pend_next[0];
                        end
                        default:
                        begin
                            byte_idx_next = byte_idx_next + 4'd1;
                            if (byte_idx_next < 4'(NUM_FIELDS)) begin
                                slot       = byte_idx_next[2:0];
                                shift_next = pend_next[slot];
                            end else if (byte_idx_next == 4'(NUM_FIELDS)) begin
                                shift_next = WP_ON;
                            end else begin
                                step_next = ST_SET_END;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    // Result of this tick
    always_comb
    begin
        result.sclk        = sclk;
        result.sda_out     = sda;
        result.sda_drive   = drive;
        result.chip_enable = ce;
        result.done_res    = done;
        result.second      = time_next[0];
        result.minute      = time_next[1];
        result.hour        = time_next[2][5:0];
        result.day         = time_next[3][5:0];
        result.month       = time_next[4][4:0];
        result.weekday     = time_next[5][2:0];
        result.year        = time_next[6];
    end

endmodule

>>> sv/rtcb_checker.sv
module rtcb_checker
    import rtcb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input rtcb_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input rtcb_out_t out_data
);

    // A request that is not yet taken holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("request changed while stalled");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The closing tick of a request has chip enable low
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.chip_enable && !out_data.sclk)
        else $error("done pulse during an active transaction");

    // The line is released only inside a transaction, and then reads as zero
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.sda_drive |-> out_data.chip_enable && !out_data.sda_out)
        else $error("data line released outside a read");

    // With chip enable low the pins sit at their idle levels
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.chip_enable |->
            !out_data.sclk && out_data.sda_drive && out_data.sda_out)
        else $error("pins not idle with chip enable low");

endmodule

bind rtc_three_wire_burst_master_core rtcb_checker u_rtcb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
